// ===== hw/rtl/shc_pkg.sv =====
package shc_pkg;

    // Default depth of the byte window.
    localparam int SHC_WINDOW_BYTES = 24;

    // Pattern identifiers.
    localparam int NUM_PATS      = 6;
    localparam int PAT_STORYDATA = 0;
    localparam int PAT_TWEE      = 1;
    localparam int PAT_HTML      = 2;
    localparam int PAT_DOCTYPE   = 3;
    localparam int PAT_META      = 4;
    localparam int PAT_IFID      = 5;

    // Lower-case patterns; the first character sits in the highest byte.
    localparam logic [8*13-1:0] STR_STORYDATA = "<tw-storydata";
    localparam logic [8*15-1:0] STR_TWEE      = "modifier=\"twee\"";
    localparam logic [8*5-1:0]  STR_HTML      = "<html";
    localparam logic [8*14-1:0] STR_DOCTYPE   = "<!doctype html";
    localparam logic [8*5-1:0]  STR_META      = "<meta";
    localparam logic [8*24-1:0] STR_IFID      = "property=\"ifiction:ifid\"";

    localparam int LEN_STORYDATA = $bits(STR_STORYDATA) / 8;
    localparam int LEN_TWEE      = $bits(STR_TWEE) / 8;
    localparam int LEN_HTML      = $bits(STR_HTML) / 8;
    localparam int LEN_DOCTYPE   = $bits(STR_DOCTYPE) / 8;
    localparam int LEN_META      = $bits(STR_META) / 8;
    localparam int LEN_IFID      = $bits(STR_IFID) / 8;

    // Longest pattern; the window must be at least this deep.
    localparam int MAX_PAT_LEN = LEN_IFID;

    // One match bit per pattern.
    typedef logic [NUM_PATS-1:0] shc_match_t;

    // Length of a pattern in bytes.
    function automatic int pat_len(input int pat);
        case (pat)
            PAT_STORYDATA: return LEN_STORYDATA;
            PAT_TWEE:      return LEN_TWEE;
            PAT_HTML:      return LEN_HTML;
            PAT_DOCTYPE:   return LEN_DOCTYPE;
            PAT_META:      return LEN_META;
            PAT_IFID:      return LEN_IFID;
            default:       return 0;
        endcase
    endfunction

    // Pattern byte at a distance pos from its last character.
    function automatic logic [7:0] pat_byte(input int pat, input int pos);
        logic [7:0] b;
        b = 8'h00;
        case (pat)
            PAT_STORYDATA: if (pos < LEN_STORYDATA) b = STR_STORYDATA[8*pos +: 8];
            PAT_TWEE:      if (pos < LEN_TWEE)      b = STR_TWEE[8*pos +: 8];
            PAT_HTML:      if (pos < LEN_HTML)      b = STR_HTML[8*pos +: 8];
            PAT_DOCTYPE:   if (pos < LEN_DOCTYPE)   b = STR_DOCTYPE[8*pos +: 8];
            PAT_META:      if (pos < LEN_META)      b = STR_META[8*pos +: 8];
            PAT_IFID:      if (pos < LEN_IFID)      b = STR_IFID[8*pos +: 8];
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/shc_cell.sv =====
module shc_cell #(
    parameter int CELL_POS = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  logic               clear,
    input  logic [7:0]         byte_in,
    output logic [7:0]         byte_out,
    output shc_pkg::shc_match_t match
);
    import shc_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Each pattern checks the byte that lands in this cell on the current transfer.
    // A pattern no longer than this cell's distance from the newest byte does not care.
    for (genvar p = 0; p < NUM_PATS; p++) begin : g_pat
        if (CELL_POS < pat_len(p)) begin : g_cmp
            assign match[p] = (byte_in == pat_byte(p, CELL_POS));
        end else begin : g_dont_care
            assign match[p] = 1'b1;
        end
    end

    // Window byte: cleared at the end of a file, else shifted on each input transfer.
    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = 8'h00;
        end else if (shift_en) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== hw/rtl/html_story_signature_classifier.sv =====
// HTML story signature classifier.
// A file streams in on the s_ channel one byte per transfer; s_tlast marks
// its final byte. Each byte is folded to lower case and shifted into a row of
// window cells, each cell holding one byte and comparing the byte that lands
// in it against the pattern characters at its distance from the newest byte.
// Matches of the signature patterns set a sticky flag; a meta tag arms the
// ifid property check until the next '<' or '>'.
// Only the final byte of a file yields a result: one transfer on the m_
// channel, m_tdata[0] = 1 when the file is claimed as an HTML story. The
// result is registered and shows in the cycle after the final byte is
// taken. The block takes one byte every cycle; the single output register
// is the only place a result waits, so s_tready drops only while a verdict
// is held and m_tready is low. After the final byte the window and flags
// clear, so the next byte starts a new file. Reset (aresetn low,
// synchronous) clears the window, the flags and the output register.
module html_story_signature_classifier #(
    parameter int WINDOW_BYTES = shc_pkg::SHC_WINDOW_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] story_valid, [7:1] zero
);
    import shc_pkg::*;

    logic       in_xfer;
    logic       file_end;
    logic [7:0] folded_byte;
    logic       is_angle;

    logic [7:0] cell_byte [WINDOW_BYTES];
    shc_match_t cell_match [WINDOW_BYTES];
    shc_match_t match_acc [WINDOW_BYTES+1];
    shc_match_t hits;

    logic signature_reg;
    logic signature_next;
    logic meta_armed_reg;
    logic meta_armed_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic story_reg;
    logic story_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign file_end = in_xfer && s_tlast;

    // Fold ASCII upper case to lower case.
    always_comb begin
        folded_byte = s_tdata;
        if (s_tdata >= "A" && s_tdata <= "Z") begin
            folded_byte = s_tdata + 8'd32;
        end
    end

    assign is_angle = (folded_byte == "<") || (folded_byte == ">");

    // Row of window cells; cell 0 takes the new byte, each other its neighbor's byte.
    for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
        if (i == 0) begin : g_head
            shc_cell #(.CELL_POS(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (in_xfer),
                .clear    (file_end),
                .byte_in  (folded_byte),
                .byte_out (cell_byte[i]),
                .match    (cell_match[i])
            );
        end else begin : g_body
            shc_cell #(.CELL_POS(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (in_xfer),
                .clear    (file_end),
                .byte_in  (cell_byte[i-1]),
                .byte_out (cell_byte[i]),
                .match    (cell_match[i])
            );
        end
    end

    // A pattern matches when every cell it covers agrees.
    assign match_acc[0] = '1;
    for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_and
        assign match_acc[i+1] = match_acc[i] & cell_match[i];
    end
    assign hits = match_acc[WINDOW_BYTES];

    // Flag updates; the ifid check sees the meta flag from before this byte.
    always_comb begin
        signature_next  = signature_reg;
        meta_armed_next = meta_armed_reg;
        if (in_xfer) begin
            if (hits[PAT_STORYDATA] || hits[PAT_TWEE] || hits[PAT_HTML]
                || hits[PAT_DOCTYPE] || (meta_armed_reg && hits[PAT_IFID])) begin
                signature_next = 1'b1;
            end
            if (is_angle) begin
                meta_armed_next = 1'b0;
            end
            if (hits[PAT_META]) begin
                meta_armed_next = 1'b1;
            end
        end
    end

    // Output register; a verdict is loaded at the end of each file.
    always_comb begin
        m_valid_next = m_valid_reg;
        story_next   = story_reg;
        if (file_end) begin
            m_valid_next = 1'b1;
            story_next   = signature_next;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signature_reg  <= 1'b0;
            meta_armed_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            story_reg      <= 1'b0;
        end else begin
            signature_reg  <= file_end ? 1'b0 : signature_next;
            meta_armed_reg <= file_end ? 1'b0 : meta_armed_next;
            m_valid_reg    <= m_valid_next;
            story_reg      <= story_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, story_reg};

`ifndef SYNTHESIS
    // The flags start clean after the end of a file.
    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        file_end |=> (!signature_reg && !meta_armed_reg))
        else $error("flags not cleared after final byte");

    // The window's head cell starts clean after the end of a file.
    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        file_end |=> (cell_byte[0] == 8'h00))
        else $error("window not cleared after final byte");

    // A verdict appears only after a final byte was taken.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(file_end))
        else $error("result without a final byte");
`endif

endmodule

// ===== tb/html_story_signature_classifier_tb.sv =====
module html_story_signature_classifier_tb;
    import shc_pkg::*;

    localparam int WIN = SHC_WINDOW_BYTES;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] story_valid, [7:1] zero

    html_story_signature_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Signature strings, indexed by the package pattern identifiers.
    string sig_text [NUM_PATS] = '{
        "<tw-storydata",
        "modifier=\"twee\"",
        "<html",
        "<!doctype html",
        "<meta",
        "property=\"ifiction:ifid\""
    };

    // Local copy of the classifier state.
    logic [7:0] story_win [WIN];
    bit         sig_flag;
    bit         meta_flag;

    // Verdicts still owed by the block, oldest first.
    logic       verdict_q [$];
    int         mismatches = 0;

    // Sender bookkeeping.
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         files_done = 0;
    logic [7:0] file_q [$];

    // Long receiver hold-off requests, served by the receiver process.
    int         hold_requests = 0;
    int         hold_served   = 0;
    int         hold_left     = 0;
    int         rx_tick       = 0;
    int         rx_mode       = 0;

    logic       owed;

    // Directed files; a verdict is pinned only where it is obvious.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic       verdict;
    } dir_row_t;

    dir_row_t dir_rows [0:22] = '{
        // Upper-case letters fold, and a match on the final byte counts.
        '{"<", 1'b0, 1'b0, 1'b0},
        '{"H", 1'b0, 1'b0, 1'b0},
        '{"t", 1'b0, 1'b0, 1'b0},
        '{"M", 1'b0, 1'b0, 1'b0},
        '{"l", 1'b1, 1'b1, 1'b1},
        // Lone final bytes at both extremes.
        '{8'h00, 1'b1, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b0},
        // A tag split across two files must not match.
        '{"<", 1'b0, 1'b0, 1'b0},
        '{"h", 1'b0, 1'b0, 1'b0},
        '{"t", 1'b1, 1'b1, 1'b0},
        '{"m", 1'b0, 1'b0, 1'b0},
        '{"l", 1'b1, 1'b1, 1'b0},
        // A non-ASCII byte is not folded.
        '{"<", 1'b0, 1'b0, 1'b0},
        '{8'hC8, 1'b0, 1'b0, 1'b0},
        '{"t", 1'b0, 1'b0, 1'b0},
        '{"m", 1'b0, 1'b0, 1'b0},
        '{"l", 1'b1, 1'b1, 1'b0},
        // A meta tag closed on the final byte.
        '{"<", 1'b0, 1'b0, 1'b0},
        '{"m", 1'b0, 1'b0, 1'b0},
        '{"E", 1'b0, 1'b0, 1'b0},
        '{"t", 1'b0, 1'b0, 1'b0},
        '{"a", 1'b0, 1'b0, 1'b0},
        '{">", 1'b1, 1'b0, 1'b0}
    };

    task automatic note_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_story_state();
        for (int i = 0; i < WIN; i++) story_win[i] = 8'h00;
        sig_flag  = 1'b0;
        meta_flag = 1'b0;
    endtask

    // True when the newest bytes of the window spell the given text.
    function automatic bit window_tail(input string p);
        int n;
        bit hit;
        n   = p.len();
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (story_win[WIN - n + i] != p[i]) hit = 1'b0;
        end
        return hit;
    endfunction

    // Advance the local classifier by one byte; a final byte yields a verdict.
    task automatic classify_byte(input logic [7:0] raw, input logic fin,
                                 output bit has_verdict, output logic verdict);
        logic [7:0] b;
        b = raw;
        if (b >= "A" && b <= "Z") b = b + 8'd32;
        for (int i = 0; i < WIN - 1; i++) story_win[i] = story_win[i + 1];
        story_win[WIN - 1] = b;

        if (window_tail(sig_text[PAT_STORYDATA]) || window_tail(sig_text[PAT_TWEE]) ||
            window_tail(sig_text[PAT_HTML]) || window_tail(sig_text[PAT_DOCTYPE]))
            sig_flag = 1'b1;
        if (meta_flag && window_tail(sig_text[PAT_IFID])) sig_flag = 1'b1;

        // Angle brackets disarm before the meta compare on the same byte.
        if (b == "<" || b == ">") meta_flag = 1'b0;
        if (window_tail(sig_text[PAT_META])) meta_flag = 1'b1;

        has_verdict = fin;
        verdict     = sig_flag;
        if (fin) clear_story_state();
    endtask

    // Offer one byte in bursts with random gaps, and record the verdict it owes.
    task automatic offer_byte(input logic [7:0] d, input logic l,
                              input logic pinned, input logic pinned_v);
        int   gap;
        bit   has_v;
        logic v;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
        classify_byte(d, l, has_v, v);
        if (has_v) begin
            verdict_q.push_back(pinned ? pinned_v : v);
            files_done++;
        end
    endtask

    // Hold the input until every owed verdict has come back.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    // Append text to the file under construction, with random case when asked.
    task automatic add_text(input string p, input bit mixed);
        logic [7:0] c;
        for (int i = 0; i < p.len(); i++) begin
            c = p[i];
            if (mixed && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
            file_q.push_back(c);
        end
    endtask

    task automatic add_noise(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0)      file_q.push_back("<");
            else if (k == 1) file_q.push_back(">");
            else if (k == 2) file_q.push_back(" ");
            else             file_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Build one random file, mostly of whole or damaged signatures.
    task automatic build_file();
        int    frags;
        int    kind;
        int    pat;
        int    cut;
        int    pos;
        string p;
        file_q.delete();
        if ($urandom_range(0, 19) == 0) begin
            file_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        frags = $urandom_range(1, 4);
        for (int f = 0; f < frags; f++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                add_noise($urandom_range(1, 5));
            end else if (kind <= 5) begin
                // A signature, whole, cut short, or with one byte damaged.
                pat = $urandom_range(0, NUM_PATS - 1);
                p   = sig_text[pat];
                cut = $urandom_range(0, 9);
                if (cut == 0) begin
                    p = p.substr(0, $urandom_range(0, p.len() - 2));
                    add_text(p, 1'($urandom_range(0, 1)));
                end else if (cut == 1) begin
                    pos = file_q.size() + $urandom_range(0, p.len() - 1);
                    add_text(p, 1'($urandom_range(0, 1)));
                    file_q[pos] = 8'($urandom_range(0, 255));
                end else begin
                    add_text(p, 1'($urandom_range(0, 1)));
                end
            end else if (kind <= 8) begin
                // A meta tag carrying the ifid property, sometimes broken off.
                add_text(sig_text[PAT_META], 1'($urandom_range(0, 1)));
                add_text(" ", 1'b0);
                pos = $urandom_range(0, 5);
                if (pos == 0)      file_q.push_back(">");
                else if (pos == 1) file_q.push_back("<");
                else if (pos == 2) add_text("name=\"x\" ", 1'b1);
                add_text(sig_text[PAT_IFID], 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1)) add_text(" content=\"id\">", 1'b0);
            end else begin
                // The ifid property with no meta tag in force.
                add_text(sig_text[PAT_IFID], 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Receiver: stalls on rotating patterns, plus long hold-offs on request.
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_tick % 5) >= 2;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each result transfer with the oldest owed verdict.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                note_mismatch($sformatf("result 0x%02h with no verdict owed", m_tdata));
            end else begin
                owed = verdict_q.pop_front();
                if (m_tdata[0] !== owed)
                    note_mismatch($sformatf("story_valid %b, want %b", m_tdata[0], owed));
                if (m_tdata[7:1] !== 7'd0)
                    note_mismatch($sformatf("padding bits 0x%02h not zero", m_tdata[7:1]));
            end
        end
    end

    // Main sequence.
    initial begin
        clear_story_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_byte(dir_rows[i].data, dir_rows[i].last,
                       dir_rows[i].pinned, dir_rows[i].verdict);
        drain_verdicts();

        while (bytes_sent < 1400 || files_done < 48) begin
            if (files_done == 12) begin
                // Short files against a stalled receiver, to back up the input.
                hold_requests++;
                burst_left = 1000;
                for (int k = 0; k < 20; k++)
                    offer_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
            end
            if (files_done % 15 == 14) drain_verdicts();
            build_file();
            foreach (file_q[j])
                offer_byte(file_q[j], j == file_q.size() - 1, 1'b0, 1'b0);
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("html_story_signature_classifier: match");
        end else begin
            $display("html_story_signature_classifier: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("html_story_signature_classifier: mismatch");
        $finish;
    end

endmodule
